// ===== hdl/imam_pkg.sv =====
// shared types and constants of the integer matrix add / multiply block
// no dependencies
package imam_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int OP_W      = 2;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int TDATA_W   = 40;

   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 3'd4;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic              first;
      logic              fin_t;
      logic              last;
      logic [STAT_W-1:0] status;
   } tok_type;

endpackage

// ===== hdl/integer_matrix_add_multiply.sv =====
// Integer matrix add / multiply. While idle, loads write one element of A or B per cycle
// into two synchronous memories; a run walks the result in row-major order through a read
// stage, a multiply/add stage and an accumulate stage, one memory read pair per cycle while
// the output is not stalled. A run issues rows*cols steps for addition and
// rows_a*cols_b*cols_a for multiplication (one multiply-accumulate step at a time, set by
// the single read port of each memory); a failed check or an empty addition gives a
// single status word. A new item is taken once the last step of a run has issued. Output
// stalls hold the whole walk.
// depends on imam_pkg and imam_mac
module integer_matrix_add_multiply import imam_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // elem_row, elem_col, elem_value, zero pad
   input  logic [OP_W-1:0]      req_tuser,   // op
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,   // out_row, out_col, result_value, zero pad
   output logic [STAT_W-1:0]    rsp_tuser,   // status
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WALK   = 3'b010,
      S_STATUS = 3'b100
   } seq_state_type;

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
      logic [2*IDX_W-1:0] lin;
      lin = {{IDX_W{1'b0}}, r} * (2*IDX_W)'(MAX_DIM) + {{IDX_W{1'b0}}, c};
      return lin[ADDR_W-1:0];
   endfunction

   logic [DATA_W-1:0] mem_a [DEPTH];
   logic [DATA_W-1:0] mem_b [DEPTH];
   logic [DATA_W-1:0] a_rd_ff;
   logic [DATA_W-1:0] b_rd_ff;

   logic [DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic             mode_ff;

   seq_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   tok_type           tok_ff, tok_in;

   logic [IDX_W-1:0]  elem_row, elem_col;
   logic [DATA_W-1:0] elem_value;
   logic              req_fire, load_ok, en;
   logic              too_big, add_bad, add_empty, mul_bad;
   logic [DIM_W-1:0]  k_dim, n_dim;
   logic              last_t, last_j, last_i;
   logic [ADDR_W-1:0] a_addr, b_addr, w_addr;

   logic [IDX_W-1:0]  out_row, out_col;
   logic [DATA_W-1:0] result_value;

   assign elem_row   = req_tdata[IDX_W-1:0];
   assign elem_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign elem_value = req_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= '0;
         cols_a_ff <= '0;
         rows_b_ff <= '0;
         cols_b_ff <= '0;
         mode_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROWS_A: rows_a_ff <= csr_data;
            REG_COLS_A: cols_a_ff <= csr_data;
            REG_ROWS_B: rows_b_ff <= csr_data;
            REG_COLS_B: cols_b_ff <= csr_data;
            REG_MODE:   mode_ff   <= csr_data[0];
            default:    ;
         endcase
      end
   end

   // dimension checks
   always_comb begin
      too_big   = rows_a_ff > DIM_W'(MAX_DIM) || cols_a_ff > DIM_W'(MAX_DIM) ||
                  rows_b_ff > DIM_W'(MAX_DIM) || cols_b_ff > DIM_W'(MAX_DIM);
      add_bad   = rows_a_ff != rows_b_ff || cols_a_ff != cols_b_ff;
      add_empty = rows_a_ff == '0 || cols_a_ff == '0;
      mul_bad   = cols_a_ff != rows_b_ff || rows_a_ff == '0 || cols_a_ff == '0 ||
                  rows_b_ff == '0 || cols_b_ff == '0;
      k_dim     = mode_ff ? cols_a_ff : DIM_W'(1);
      n_dim     = mode_ff ? cols_b_ff : cols_a_ff;
      last_t    = (DIM_W'(t_ff) + DIM_W'(1)) == k_dim;
      last_j    = (DIM_W'(j_ff) + DIM_W'(1)) == n_dim;
      last_i    = (DIM_W'(i_ff) + DIM_W'(1)) == rows_a_ff;
   end

   // walk sequencer
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      t_in     = t_ff;
      stat_in  = stat_ff;
      tok_in   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser == OP_RUN) begin
               i_in = '0;
               j_in = '0;
               t_in = '0;
               if (too_big || (!mode_ff && add_bad) || (mode_ff && mul_bad)) begin
                  stat_in  = ST_MISMATCH;
                  state_in = S_STATUS;
               end else if (!mode_ff && add_empty) begin
                  stat_in  = ST_EMPTY;
                  state_in = S_STATUS;
               end else begin
                  stat_in  = ST_OK;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            tok_in.valid  = 1'b1;
            tok_in.row    = i_ff;
            tok_in.col    = j_ff;
            tok_in.first  = (t_ff == '0);
            tok_in.fin_t  = last_t;
            tok_in.last   = last_t && last_j && last_i;
            tok_in.status = ST_OK;
            if (en) begin
               if (!last_t) begin
                  t_in = t_ff + IDX_W'(1);
               end else begin
                  t_in = '0;
                  if (!last_j) begin
                     j_in = j_ff + IDX_W'(1);
                  end else begin
                     j_in = '0;
                     if (!last_i) begin
                        i_in = i_ff + IDX_W'(1);
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
               end
            end
         end
         S_STATUS: begin
            tok_in.valid  = 1'b1;
            tok_in.first  = 1'b1;
            tok_in.fin_t  = 1'b1;
            tok_in.last   = 1'b1;
            tok_in.status = stat_ff;
            if (en) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      t_ff    <= t_in;
      stat_ff <= stat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (en) begin
         tok_ff.valid <= tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tok_ff.row    <= tok_in.row;
         tok_ff.col    <= tok_in.col;
         tok_ff.first  <= tok_in.first;
         tok_ff.fin_t  <= tok_in.fin_t;
         tok_ff.last   <= tok_in.last;
         tok_ff.status <= tok_in.status;
      end
   end

   // element memories
   always_comb begin
      a_addr  = mode_ff ? elem_addr(i_ff, t_ff) : elem_addr(i_ff, j_ff);
      b_addr  = mode_ff ? elem_addr(t_ff, j_ff) : elem_addr(i_ff, j_ff);
      w_addr  = elem_addr(elem_row, elem_col);
      load_ok = {1'b0, elem_row} < DIM_W'(MAX_DIM) && {1'b0, elem_col} < DIM_W'(MAX_DIM);
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == OP_LOAD_A && load_ok) begin
         mem_a[w_addr] <= elem_value;
      end
      if (en) begin
         a_rd_ff <= mem_a[a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == OP_LOAD_B && load_ok) begin
         mem_b[w_addr] <= elem_value;
      end
      if (en) begin
         b_rd_ff <= mem_b[b_addr];
      end
   end

   imam_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .tok_in     (tok_ff),
      .a_rd       (a_rd_ff),
      .b_rd       (b_rd_ff),
      .rsp_ready  (rsp_tready),
      .en         (en),
      .rsp_valid  (rsp_tvalid),
      .rsp_row    (out_row),
      .rsp_col    (out_col),
      .rsp_value  (result_value),
      .rsp_status (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {(TDATA_W-2*IDX_W-DATA_W)'(0), result_value, out_col, out_row};

endmodule

// ===== hdl/imam_mac.sv =====
// multiply / add stage, dot-product accumulator and result register
// depends on imam_pkg
module imam_mac import imam_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              mode,
   input  tok_type           tok_in,
   input  logic [DATA_W-1:0] a_rd,
   input  logic [DATA_W-1:0] b_rd,
   input  logic              rsp_ready,
   output logic              en,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_row,
   output logic [IDX_W-1:0]  rsp_col,
   output logic [DATA_W-1:0] rsp_value,
   output logic [STAT_W-1:0] rsp_status,
   output logic              rsp_last
);

   tok_type           tok_ff;
   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] val_in;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  row_ff;
   logic [IDX_W-1:0]  col_ff;
   logic [DATA_W-1:0] value_ff;
   logic [STAT_W-1:0] status_ff;
   logic              last_ff;

   always_comb begin
      en     = !rsp_valid_ff || rsp_ready;
      val_in = mode ? a_rd * b_rd : a_rd + b_rd;
      acc_in = (tok_ff.first ? '0 : acc_ff) + val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         tok_ff.valid <= tok_in.valid;
         rsp_valid_ff <= tok_ff.valid && tok_ff.fin_t;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tok_ff.row    <= tok_in.row;
         tok_ff.col    <= tok_in.col;
         tok_ff.first  <= tok_in.first;
         tok_ff.fin_t  <= tok_in.fin_t;
         tok_ff.last   <= tok_in.last;
         tok_ff.status <= tok_in.status;
         val_ff        <= val_in;
         if (tok_ff.valid) begin
            acc_ff <= acc_in;
         end
         if (tok_ff.valid && tok_ff.fin_t) begin
            row_ff    <= tok_ff.row;
            col_ff    <= tok_ff.col;
            value_ff  <= (tok_ff.status == ST_OK) ? acc_in : '0;
            status_ff <= tok_ff.status;
            last_ff   <= tok_ff.last;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_row    = row_ff;
   assign rsp_col    = col_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== hdl/imam_checker.sv =====
// port-level checks of the integer matrix add / multiply block, bound to the top level
// depends on imam_pkg and integer_matrix_add_multiply
module imam_checker import imam_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [OP_W-1:0]      req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [TDATA_W-1:0]   rsp_tdata,
   input logic [STAT_W-1:0]    rsp_tuser,
   input logic                 rsp_tlast
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // error and empty words end the run and carry zeros
   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tlast && rsp_tdata == '0)
      else $error("status word not final or not zero");

   // a run blocks the input side for at least the next cycle
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_RUN |=> !req_tready)
      else $error("input taken right after a run word");

endmodule

bind integer_matrix_add_multiply imam_checker u_imam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
